@@ hdl/pfx_eval_pkg.sv @@
// Shared types, character codes and status codes of the postfix evaluator.
package pfx_eval_pkg;

  // Characters of the expression language.
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_MOD  = 8'h25;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;

  typedef struct packed {
    logic [7:0] token;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] value;
    logic [2:0]        status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       push;
    logic       rd;
    logic       set_err;
    logic [2:0] err_code;
    logic       arith_wb;
    logic       div_start;
    logic       div_wb;
    logic       emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err_active;
    logic is_digit;
    logic is_op;
    logic is_divop;
    logic sp_full;
    logic sp_lt2;
    logic rhs_zero;
    logic div_done;
    logic last;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/pfx_eval_div.sv @@
// Serial signed 8-bit divider, one quotient bit per cycle, truncating toward zero.
module pfx_eval_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic       done_o,
  output logic [7:0] quot_o,
  output logic [7:0] rem_o
);

  logic       busy_q;
  logic       done_q;
  logic [2:0] cnt_q;
  logic [7:0] quo_q;
  logic [7:0] rem_q;
  logic [7:0] dvs_q;
  logic       qneg_q;
  logic       rneg_q;

  logic [7:0] a_mag;
  logic [7:0] b_mag;
  logic [8:0] shifted;
  logic [9:0] trial;

  // Magnitudes fit in eight unsigned bits, including that of -128.
  assign a_mag   = dividend_i[7] ? 8'(-dividend_i) : dividend_i;
  assign b_mag   = divisor_i[7] ? 8'(-divisor_i) : divisor_i;
  assign shifted = {rem_q, quo_q[7]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= a_mag;
      rem_q  <= '0;
      dvs_q  <= b_mag;
      qneg_q <= dividend_i[7] ^ divisor_i[7];
      rneg_q <= dividend_i[7];
    end else if (busy_q) begin
      if (!trial[9]) begin
        rem_q <= trial[7:0];
        quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        rem_q <= shifted[7:0];
        quo_q <= {quo_q[6:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? 8'(-quo_q) : quo_q;
  assign rem_o  = rneg_q ? 8'(-rem_q) : rem_q;

endmodule

@@ hdl/pfx_eval_dp.sv @@
// Datapath: operand stack, top-of-stack register, ALU, divider and output register.
module pfx_eval_dp #(
  parameter int DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pfx_eval_pkg::in_item_t  in_data_i,
  input  pfx_eval_pkg::cmd_t      cmd_i,
  output pfx_eval_pkg::sts_t      sts_o,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output pfx_eval_pkg::out_item_t out_data_o
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SPW = $clog2(DEPTH + 1);

  // The top entry lives in tos_q; the memory holds the entries below it.
  logic [7:0]     stack_mem [DEPTH];
  logic [7:0]     tok_q;
  logic           last_q;
  logic [7:0]     tos_q;
  logic [SPW-1:0] sp_q;
  logic [2:0]     err_q;
  logic [7:0]     rd_q;
  logic           out_valid_q;
  pfx_eval_pkg::out_item_t out_q;

  logic [SPW-1:0] sp_m1;
  logic [SPW-1:0] sp_m2;
  logic           wr_en;
  logic [7:0]     alu_res;
  logic [15:0]    prod;
  logic           div_done;
  logic [7:0]     div_quot;
  logic [7:0]     div_rem;
  logic           is_divop;

  assign sp_m1 = sp_q - SPW'(1);
  assign sp_m2 = sp_q - SPW'(2);
  assign wr_en = cmd_i.push && (sp_q != '0);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[sp_m1[AW-1:0]] <= tos_q;
    end
    if (cmd_i.rd) begin
      rd_q <= stack_mem[sp_m2[AW-1:0]];
    end
  end

  assign prod = 16'($signed(rd_q) * $signed(tos_q));

  always_comb begin
    case (tok_q)
      pfx_eval_pkg::CH_ADD: alu_res = rd_q + tos_q;
      pfx_eval_pkg::CH_SUB: alu_res = rd_q - tos_q;
      default:              alu_res = prod[7:0];
    endcase
  end

  assign is_divop = (tok_q == pfx_eval_pkg::CH_DIV) || (tok_q == pfx_eval_pkg::CH_MOD);

  pfx_eval_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_q),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tok_q  <= in_data_i.token;
      last_q <= in_data_i.last;
    end
    if (cmd_i.push) begin
      tos_q <= tok_q - pfx_eval_pkg::CH_ZERO;
    end else if (cmd_i.arith_wb) begin
      tos_q <= alu_res;
    end else if (cmd_i.div_wb) begin
      tos_q <= (tok_q == pfx_eval_pkg::CH_DIV) ? div_quot : div_rem;
    end
    if (cmd_i.emit) begin
      if (err_q != pfx_eval_pkg::ST_OK) begin
        out_q.value  <= '0;
        out_q.status <= err_q;
      end else if (sp_q == '0) begin
        out_q.value  <= '0;
        out_q.status <= pfx_eval_pkg::ST_EMPTY;
      end else begin
        out_q.value  <= tos_q;
        out_q.status <= pfx_eval_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      err_q       <= pfx_eval_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        sp_q  <= '0;
        err_q <= pfx_eval_pkg::ST_OK;
      end else begin
        if (cmd_i.push) begin
          sp_q <= sp_q + SPW'(1);
        end else if (cmd_i.arith_wb || cmd_i.div_wb) begin
          sp_q <= sp_m1;
        end
        if (cmd_i.set_err) begin
          err_q <= cmd_i.err_code;
        end
      end
      out_valid_q <= cmd_i.emit || (out_valid_q && out_stall_i);
    end
  end

  always_comb begin
    sts_o.err_active = (err_q != pfx_eval_pkg::ST_OK);
    sts_o.is_digit   = (tok_q >= pfx_eval_pkg::CH_ZERO) && (tok_q <= pfx_eval_pkg::CH_NINE);
    sts_o.is_op      = (tok_q == pfx_eval_pkg::CH_ADD) || (tok_q == pfx_eval_pkg::CH_SUB) ||
                       (tok_q == pfx_eval_pkg::CH_MUL) || is_divop;
    sts_o.is_divop   = is_divop;
    sts_o.sp_full    = (sp_q == SPW'(DEPTH));
    sts_o.sp_lt2     = (sp_q < SPW'(2));
    sts_o.rhs_zero   = (tos_q == '0);
    sts_o.div_done   = div_done;
    sts_o.last       = last_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_sp_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(DEPTH))
    else $error("stack pointer beyond depth");

  a_emit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (sp_q == '0) && (err_q == pfx_eval_pkg::ST_OK) && out_valid_q)
    else $error("expression state not cleared after result");

  a_err_value_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != pfx_eval_pkg::ST_OK) |-> (out_q.value == '0))
    else $error("non-zero value with error status");

  a_pop_needs_two : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.arith_wb || cmd_i.div_wb |-> sp_q >= SPW'(2))
    else $error("pop with fewer than two entries");

endmodule

@@ hdl/pfx_eval_ctrl.sv @@
// Controller: sequences decode, stack read, arithmetic and result transfer per character.
module pfx_eval_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pfx_eval_pkg::sts_t sts_i,
  output pfx_eval_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_DIVW   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        if (!sts_i.err_active) begin
          if (sts_i.is_digit) begin
            if (sts_i.sp_full) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = pfx_eval_pkg::ST_OVERFLOW;
            end else begin
              cmd_o.push = 1'b1;
            end
          end else if (sts_i.is_op) begin
            if (sts_i.sp_lt2) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = pfx_eval_pkg::ST_UNDERFLOW;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_d = S_FINISH;
        if (sts_i.is_divop && sts_i.rhs_zero) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = pfx_eval_pkg::ST_DIVZERO;
        end else if (sts_i.is_divop) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVW;
        end else begin
          cmd_o.arith_wb = 1'b1;
        end
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.div_wb = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_FINISH: begin
        // The final character waits here until the output register is free.
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == S_DIVW)
    else $error("divider started without waiting for it");

  a_emit_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.last && sts_i.out_free)
    else $error("result transfer for a character that is not final");

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_DECODE)
    else $error("accepted character not decoded");

endmodule

@@ hdl/postfix_expression_evaluator_core.sv @@
// Postfix expression evaluator top level: controller, datapath and handshake ports.
// Steps: a digit or ignored character is decoded and finished; + - * also read the stack
// and write back, and / % also wait in S_DIVW until the serial divider is done.
// Throughput: one character at a time; the next is not taken before the last is through.
// The result of a final character is registered once the output register is free.
// Reset (rst_ni, asynchronous, active low) empties the stack, clears the error and output valid.
module postfix_expression_evaluator_core #(
  parameter int DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  pfx_eval_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output pfx_eval_pkg::out_item_t out_data_o
);

  pfx_eval_pkg::cmd_t cmd;
  pfx_eval_pkg::sts_t sts;

  pfx_eval_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfx_eval_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/postfix_expression_evaluator_core_tb.sv @@
// Self-checking testbench for the postfix expression evaluator core.
`timescale 1ns / 1ps

module postfix_expression_evaluator_core_tb;

  localparam int DEPTH = 16;
  localparam int IDLE_PERCENT = 23;
  localparam int RANDOM_CHARS = 220;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 32;
  localparam int TIMEOUT_NS = 1_000_000;
  localparam int MAX_REPORTS = 50;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  pfx_eval_pkg::in_item_t  in_data_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  pfx_eval_pkg::out_item_t out_data_o;

  // Evaluator state as predicted from the accepted characters.
  logic signed [7:0]       eval_stack [DEPTH];
  int                      eval_depth = 0;
  logic [2:0]              eval_error = pfx_eval_pkg::ST_OK;
  pfx_eval_pkg::out_item_t expected_results [$];

  logic [7:0] expr_chars [$];
  int         mismatches = 0;
  int         useful_chars = 0;
  bit         steady = 1'b0;
  int         hold_requests = 0;

  postfix_expression_evaluator_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic bit is_digit(logic [7:0] token);
    return token >= pfx_eval_pkg::CH_ZERO && token <= pfx_eval_pkg::CH_NINE;
  endfunction

  function automatic bit is_operator(logic [7:0] token);
    return token == pfx_eval_pkg::CH_ADD || token == pfx_eval_pkg::CH_SUB ||
           token == pfx_eval_pkg::CH_MUL || token == pfx_eval_pkg::CH_DIV ||
           token == pfx_eval_pkg::CH_MOD;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(4))
      0: return pfx_eval_pkg::CH_ADD;
      1: return pfx_eval_pkg::CH_SUB;
      2: return pfx_eval_pkg::CH_MUL;
      3: return pfx_eval_pkg::CH_DIV;
      default: return pfx_eval_pkg::CH_MOD;
    endcase
  endfunction

  function automatic logic [7:0] random_noise();
    logic [7:0] token;
    do token = 8'($urandom_range(255));
    while (is_digit(token) || is_operator(token));
    return token;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Applies one accepted character and queues the result of a final character.
  task automatic evaluate_char(pfx_eval_pkg::in_item_t item);
    int lhs;
    int rhs;
    int res;
    pfx_eval_pkg::out_item_t outcome;
    if (eval_error == pfx_eval_pkg::ST_OK) begin
      if (is_digit(item.token)) begin
        if (eval_depth >= DEPTH) begin
          eval_error = pfx_eval_pkg::ST_OVERFLOW;
        end else begin
          eval_stack[eval_depth] = 8'(item.token - pfx_eval_pkg::CH_ZERO);
          eval_depth++;
        end
      end else if (is_operator(item.token)) begin
        if (eval_depth < 2) begin
          eval_error = pfx_eval_pkg::ST_UNDERFLOW;
        end else begin
          rhs = eval_stack[eval_depth-1];
          lhs = eval_stack[eval_depth-2];
          if ((item.token == pfx_eval_pkg::CH_DIV || item.token == pfx_eval_pkg::CH_MOD) &&
              rhs == 0) begin
            eval_error = pfx_eval_pkg::ST_DIVZERO;
          end else begin
            case (item.token)
              pfx_eval_pkg::CH_ADD: res = lhs + rhs;
              pfx_eval_pkg::CH_SUB: res = lhs - rhs;
              pfx_eval_pkg::CH_MUL: res = lhs * rhs;
              pfx_eval_pkg::CH_DIV: res = lhs / rhs;
              default: res = lhs % rhs;
            endcase
            eval_stack[eval_depth-2] = res[7:0];
            eval_depth--;
          end
        end
      end
    end
    if (item.last) begin
      outcome.status = eval_error;
      outcome.value = '0;
      if (eval_error == pfx_eval_pkg::ST_OK) begin
        if (eval_depth == 0) outcome.status = pfx_eval_pkg::ST_EMPTY;
        else outcome.value = eval_stack[eval_depth-1];
      end
      expected_results.push_back(outcome);
      eval_depth = 0;
      eval_error = pfx_eval_pkg::ST_OK;
    end
  endtask

  // Offers one character and waits for its transfer.
  task automatic send_char(logic [7:0] token, logic last);
    pfx_eval_pkg::in_item_t item;
    item.token = token;
    item.last = last;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    evaluate_char(item);
  endtask

  task automatic send_expression();
    foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
    expr_chars.delete();
  endtask

  task automatic queue_text(string text);
    for (int i = 0; i < text.len(); i++) expr_chars.push_back(text[i]);
  endtask

  // Mostly well-formed expressions with random content; the rest are broken or noisy.
  task automatic build_random_expression();
    int kind;
    int digits_left;
    int held;
    logic [7:0] token;
    kind = $urandom_range(19);
    held = 0;
    if (kind < 16) begin
      digits_left = (kind == 0) ? $urandom_range(DEPTH - 2, DEPTH + 2) : $urandom_range(1, 8);
      while (digits_left > 0 || held > 1) begin
        if (digits_left > 0 && (kind == 0 || held < 2 || $urandom_range(1) == 0)) begin
          expr_chars.push_back(8'(pfx_eval_pkg::CH_ZERO + $urandom_range(9)));
          digits_left--;
          held++;
        end else begin
          expr_chars.push_back(random_operator());
          held--;
        end
        if ($urandom_range(19) == 0) expr_chars.push_back(random_noise());
        // Now and then leave surplus entries on the stack.
        if (digits_left == 0 && held > 1 && $urandom_range(15) == 0) break;
      end
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(2))
          0: token = 8'(pfx_eval_pkg::CH_ZERO + $urandom_range(9));
          1: token = random_operator();
          default: token = random_noise();
        endcase
        expr_chars.push_back(token);
      end
    end
    foreach (expr_chars[i])
      if (is_digit(expr_chars[i]) || is_operator(expr_chars[i])) useful_chars++;
  endtask

  task automatic test_operators();
    // Every operator in one chain, with the lowest and highest codes ignored on the way.
    queue_text("98");
    expr_chars.push_back(8'h00);
    queue_text("+7-6*5/");
    expr_chars.push_back(8'hFF);
    queue_text("4%");
    send_expression();
    // Surplus entries below a negative top.
    queue_text("135-");
    send_expression();
  endtask

  task automatic test_error_cases();
    // Underflow stays sticky while later characters are ignored.
    queue_text("1+2");
    send_expression();
    queue_text("50/");
    send_expression();
    // Nothing but an ignored character: an empty stack at the end.
    expr_chars.push_back(8'hFF);
    send_expression();
    repeat (DEPTH + 1) expr_chars.push_back(pfx_eval_pkg::CH_NINE);
    send_expression();
    // -128 divided by -1 wraps, and its remainder is zero.
    queue_text("08-44**01-/");
    send_expression();
    queue_text("08-44**01-%");
    send_expression();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (8) begin
      build_random_expression();
      send_expression();
    end
    steady = 1'b0;
  endtask

  task automatic test_output_hold();
    // The receiver holds off while the sender keeps offering, so the block backs up.
    hold_requests++;
    steady = 1'b1;
    repeat (6) begin
      queue_text("72*3-");
      send_expression();
    end
    steady = 1'b0;
  endtask

  task automatic test_random_expressions();
    useful_chars = 0;
    while (useful_chars < RANDOM_CHARS) begin
      build_random_expression();
      send_expression();
    end
  endtask

  // Receiver side: random stalls, a requested long hold-off, or none at all.
  always @(posedge clk_i) begin : drive_out_stall
    int hold_left;
    int hold_served;
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk_i) begin : check_results
    pfx_eval_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d status %0d",
                                  out_data_o.value, out_data_o.status));
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.value !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d", out_data_o.value, want.value));
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_data_o.status, want.status));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_operators();
    test_error_cases();
    test_back_to_back();
    test_output_hold();
    test_random_expressions();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ postfix_expression_evaluator_core.f @@
hdl/pfx_eval_pkg.sv
hdl/pfx_eval_div.sv
hdl/pfx_eval_dp.sv
hdl/pfx_eval_ctrl.sv
hdl/postfix_expression_evaluator_core.sv
sim/postfix_expression_evaluator_core_tb.sv
